// ===== design/fbre_pkg.sv =====
// Shared types, constants and helper functions for the frame raster engine.
package fbre_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 384;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

  // Derived widths
  localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int X_W     = $clog2(FRAME_WIDTH + 1);
  localparam int Y_W     = $clog2(FRAME_HEIGHT + 1);
  localparam int COORD_W = 16;
  localparam int PIXEL_W = 32;
  localparam int HASH_W  = 64;
  localparam int ACT_W   = 3;
  localparam int IN_W    = 136;

  // Word-wise FNV-1a 64; the prime is 2^40 + 0x1B3
  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [8:0]        FNV_PRIME_LO = 9'h1B3;
  localparam int                FNV_SHIFT    = 40;

  // Command codes carried in tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_FILL  = 3'd1,
    ACT_SWAP  = 3'd2,
    ACT_PLOT  = 3'd3,
    ACT_HASH  = 3'd4
  } action_t;

  // Per-pixel operation of a rectangle walk
  typedef enum logic [1:0] {
    OP_FILL,
    OP_SWAP,
    OP_HASH
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_ORIGIN,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clip;
    logic origin;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
    logic want_result;
    logic out_full;
  } dp_status_t;

  // Clamp a signed coordinate to 0..hi
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One FNV-1a step on a whole pixel word
  function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [PIXEL_W-1:0] pix);
    logic [HASH_W-1:0] t;
    t = h ^ {{(HASH_W-PIXEL_W){1'b0}}, pix};
    return HASH_W'(t * HASH_W'(FNV_PRIME_LO)) + (t << FNV_SHIFT);
  endfunction

endpackage

// ===== design/fbre_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module fbre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fbre_ctrl.sv =====
// Command sequencer for the frame raster engine.
module fbre_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output fbre_pkg::ctrl_cmd_t   cmd,
  input  fbre_pkg::dp_status_t  status
);

  fbre_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbre_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = fbre_pkg::ST_CLIP;
      end
      fbre_pkg::ST_CLIP: begin
        state_next = fbre_pkg::ST_ORIGIN;
      end
      fbre_pkg::ST_ORIGIN: begin
        if (!status.empty) begin
          state_next = fbre_pkg::ST_WALK;
        end else if (status.want_result) begin
          state_next = fbre_pkg::ST_RESULT;
        end else begin
          state_next = fbre_pkg::ST_IDLE;
        end
      end
      fbre_pkg::ST_WALK: begin
        if (status.last) state_next = fbre_pkg::ST_DRAIN;
      end
      fbre_pkg::ST_DRAIN: begin
        state_next = status.want_result ? fbre_pkg::ST_RESULT : fbre_pkg::ST_IDLE;
      end
      fbre_pkg::ST_RESULT: begin
        if (!status.out_full) state_next = fbre_pkg::ST_IDLE;
      end
      default: state_next = fbre_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      fbre_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      fbre_pkg::ST_CLIP:   cmd.clip     = 1'b1;
      fbre_pkg::ST_ORIGIN: cmd.origin   = 1'b1;
      fbre_pkg::ST_WALK:   cmd.step     = 1'b1;
      fbre_pkg::ST_DRAIN:  cmd          = '0;
      fbre_pkg::ST_RESULT: cmd.out_load = !status.out_full;
      default:             cmd          = '0;
    endcase
  end

endmodule

// ===== design/fbre_datapath.sv =====
// Clipping, rectangle walker, frame store, pixel pipeline, hash and result register.
module fbre_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fbre_pkg::IN_W-1:0]       s_axis_tdata,
  input  logic [fbre_pkg::ACT_W-1:0]      s_axis_tuser,
  input  fbre_pkg::ctrl_cmd_t             cmd,
  output fbre_pkg::dp_status_t            status,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fbre_pkg::HASH_W-1:0]     m_axis_tdata
);

  localparam int CW = fbre_pkg::COORD_W;
  localparam int XW = fbre_pkg::X_W;
  localparam int YW = fbre_pkg::Y_W;
  localparam int AW = fbre_pkg::ADDR_W;
  localparam int PW = fbre_pkg::PIXEL_W;
  localparam int PROD_W = AW + 1;

  // Command registers
  fbre_pkg::action_t act;
  logic [CW-1:0]     c_left, c_top, c_right, c_bottom;
  logic [PW-1:0]     color_a, color_b;
  logic              opaque;

  // Clipped box and walk counters
  fbre_pkg::op_t op;
  logic          want_result;
  logic [XW-1:0] x0, x1, x;
  logic [YW-1:0] y0, y1, y;
  logic [AW-1:0] addr, row_base;

  // Pixel pipeline stage after the read
  logic          p1_valid;
  logic [AW-1:0] p1_addr;
  logic [PW-1:0] rd_data;

  logic [fbre_pkg::HASH_W-1:0] hash;

  // Clip combinational
  logic [CW-1:0] cl_left, cl_top, cl_right, cl_bottom, cl_right_max, cl_bottom_max;
  logic          plot_on;
  logic [XW-1:0] box_x0, box_x1;
  logic [YW-1:0] box_y0, box_y1;
  fbre_pkg::op_t box_op;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;

  logic          x_wrap;
  logic [AW-1:0] origin_addr;

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= fbre_pkg::action_t'(s_axis_tuser);
      c_left   <= s_axis_tdata[15:0];
      c_top    <= s_axis_tdata[31:16];
      c_right  <= s_axis_tdata[47:32];
      c_bottom <= s_axis_tdata[63:48];
      color_a  <= s_axis_tdata[95:64];
      color_b  <= s_axis_tdata[127:96];
      opaque   <= s_axis_tdata[128];
    end
  end

  // Clamp edges to the frame
  always_comb begin
    cl_left       = fbre_pkg::clamp_coord(c_left, CW'(fbre_pkg::FRAME_WIDTH));
    cl_top        = fbre_pkg::clamp_coord(c_top, CW'(fbre_pkg::FRAME_HEIGHT));
    cl_right      = fbre_pkg::clamp_coord(c_right, CW'(fbre_pkg::FRAME_WIDTH));
    cl_bottom     = fbre_pkg::clamp_coord(c_bottom, CW'(fbre_pkg::FRAME_HEIGHT));
    cl_right_max  = (cl_right < cl_left) ? cl_left : cl_right;
    cl_bottom_max = (cl_bottom < cl_top) ? cl_top : cl_bottom;
    plot_on = opaque && !c_left[CW-1] && (c_left < CW'(fbre_pkg::FRAME_WIDTH)) &&
              !c_top[CW-1] && (c_top < CW'(fbre_pkg::FRAME_HEIGHT));
  end

  // Turn each command into a box and a per-pixel operation
  always_comb begin
    box_op = fbre_pkg::OP_FILL;
    box_x0 = '0;
    box_x1 = '0;
    box_y0 = '0;
    box_y1 = '0;
    unique case (act) inside
      fbre_pkg::ACT_CLEAR: begin
        box_x1 = XW'(fbre_pkg::FRAME_WIDTH);
        box_y1 = YW'(fbre_pkg::FRAME_HEIGHT);
      end
      fbre_pkg::ACT_FILL, fbre_pkg::ACT_SWAP, fbre_pkg::ACT_HASH: begin
        box_x0 = cl_left[XW-1:0];
        box_x1 = cl_right_max[XW-1:0];
        box_y0 = cl_top[YW-1:0];
        box_y1 = cl_bottom_max[YW-1:0];
        if (act == fbre_pkg::ACT_SWAP) box_op = fbre_pkg::OP_SWAP;
        if (act == fbre_pkg::ACT_HASH) box_op = fbre_pkg::OP_HASH;
      end
      fbre_pkg::ACT_PLOT: begin
        // A single-pixel box, or an empty one when the pixel is skipped
        if (plot_on) begin
          box_x0 = c_left[XW-1:0];
          box_x1 = XW'(c_left[XW-1:0] + 1'b1);
          box_y0 = c_top[YW-1:0];
          box_y1 = YW'(c_top[YW-1:0] + 1'b1);
        end
      end
      default: begin
        box_op = fbre_pkg::OP_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      x0          <= box_x0;
      x1          <= box_x1;
      y0          <= box_y0;
      y1          <= box_y1;
      op          <= box_op;
      want_result <= (act == fbre_pkg::ACT_HASH);
    end
  end

  // Walk: linear address follows x/y, row base steps by the frame width
  assign origin_addr = AW'(PROD_W'(y0) * PROD_W'(fbre_pkg::FRAME_WIDTH) + PROD_W'(x0));
  assign x_wrap      = (XW'(x + 1'b1) == x1);

  always_ff @(posedge clk) begin
    if (cmd.origin) begin
      x        <= x0;
      y        <= y0;
      addr     <= origin_addr;
      row_base <= origin_addr;
    end else if (cmd.step) begin
      if (x_wrap) begin
        x        <= x0;
        y        <= YW'(y + 1'b1);
        addr     <= AW'(row_base + AW'(fbre_pkg::FRAME_WIDTH));
        row_base <= AW'(row_base + AW'(fbre_pkg::FRAME_WIDTH));
      end else begin
        x    <= XW'(x + 1'b1);
        addr <= AW'(addr + 1'b1);
      end
    end
  end

  // Read stage bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.step && (op != fbre_pkg::OP_FILL);
    end
  end

  always_ff @(posedge clk) begin
    p1_addr <= addr;
  end

  // Frame store port control: fills write at issue, swaps write after the read
  always_comb begin
    ram_re    = cmd.step && (op != fbre_pkg::OP_FILL);
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = color_a;
    if (op == fbre_pkg::OP_FILL) begin
      ram_we = cmd.step;
    end else if (op == fbre_pkg::OP_SWAP) begin
      ram_waddr = p1_addr;
      ram_we    = p1_valid && ((rd_data == color_a) || (rd_data == color_b));
      ram_wdata = (rd_data == color_a) ? color_b : color_a;
    end
  end

  fbre_ram #(
    .WIDTH (PW),
    .DEPTH (fbre_pkg::FRAME_PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Running hash
  always_ff @(posedge clk) begin
    if (cmd.origin) begin
      hash <= fbre_pkg::FNV_BASIS;
    end else if (p1_valid && (op == fbre_pkg::OP_HASH)) begin
      hash <= fbre_pkg::fnv_mix(hash, rd_data);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= hash;
    end
  end

  // Status to the controller
  always_comb begin
    status.empty       = (x0 == x1) || (y0 == y1);
    status.last        = x_wrap && (YW'(y + 1'b1) == y1);
    status.want_result = want_result;
    status.out_full    = m_axis_tvalid && !m_axis_tready;
  end

endmodule

// ===== design/framebuffer_raster_engine.sv =====
// Top level of the frame raster engine: controller plus datapath.
//
// Commands enter on the s_axis channel, one per transfer; tuser carries the
// command code (clear, fill rectangle, swap colors, plot pixel, hash rectangle)
// and tdata the edges, the two colors and the opacity bit. Only a hash command
// produces a transfer on m_axis: the 64-bit FNV-1a hash of the clipped box.
// Commands are worked one at a time. A command goes through the setup steps
// (capture, clip, origin), then walks the covered pixels one per cycle
// through the single read/write port pair of the frame store, then a drain
// state, plus a result state to load the result for a hash. Clear covers
// the whole frame (196608 pixels); plot covers at most one pixel; an empty
// box skips the walk and the drain. The next command is taken as soon as
// the block is back in idle, even while a result waits in the output
// register; a hash that finishes while that register is still held waits
// until it is taken. Reset clears the controller and the output valid; the
// frame store holds no defined contents until it is written.
module framebuffer_raster_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // left[15:0], top[31:16], right[47:32], bottom[63:48], color_a[95:64],
  // color_b[127:96], opaque[128], zero fill[135:129]
  input  logic [fbre_pkg::IN_W-1:0]    s_axis_tdata,
  // action[2:0]
  input  logic [fbre_pkg::ACT_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // region_hash[63:0]
  output logic [fbre_pkg::HASH_W-1:0]  m_axis_tdata
);

  fbre_pkg::ctrl_cmd_t  cmd;
  fbre_pkg::dp_status_t status;

  // Sequencer
  fbre_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  // Datapath with frame store
  fbre_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== design/fbre_checker.sv =====
// Port-level checks for the frame raster engine, bound to the top level.
module fbre_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [fbre_pkg::HASH_W-1:0]  m_axis_tdata
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One command at a time: busy right after a command transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while busy");

  // A new result is loaded only while the block is busy finishing a hash
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared out of idle");

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind framebuffer_raster_engine fbre_checker u_checker (.*);
